// ===== hw/rtl/odr_pkg.sv =====
package odr_pkg;

  // field widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned LevelW = 2;
  localparam int unsigned EntryW = 5;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CodeW  = 3 * LevelW;
  localparam int unsigned RowW   = 4 * EntryW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = RowW;

  // quantize mode carried by the kind field
  typedef enum logic [0:0] {
    KIND_PLAIN  = 1'b0,
    KIND_DITHER = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BAYER_ROW0 = 2'd0,
    REG_BAYER_ROW1 = 2'd1,
    REG_BAYER_ROW2 = 2'd2,
    REG_BAYER_ROW3 = 2'd3
  } cfg_reg_e;

  // one bayer row: four 5-bit entries, column c at bits 5c+4..5c
  typedef logic [3:0][EntryW-1:0] bayer_row_t;

  localparam bayer_row_t BayerRow0Rst = bayer_row_t'(20'd329984);
  localparam bayer_row_t BayerRow1Rst = bayer_row_t'(20'd211084);
  localparam bayer_row_t BayerRow2Rst = bayer_row_t'(20'd296291);
  localparam bayer_row_t BayerRow3Rst = bayer_row_t'(20'd177391);

  // band cut points
  localparam logic [ChanW-1:0] StepVal = 8'd85;
  localparam logic [ChanW-1:0] HighCut = 8'd170;

  // threshold terms, everything scaled by 32
  localparam int unsigned CmpW = 13;
  localparam logic [CmpW-1:0] ThrMul = 13'd172;
  localparam logic [CmpW-1:0] ThrOff = 13'd86;

  // plain rounding: floor((6c+255)/510) reduces to three cut points
  localparam logic [ChanW-1:0] PlainCut1 = 8'd43;
  localparam logic [ChanW-1:0] PlainCut2 = 8'd128;
  localparam logic [ChanW-1:0] PlainCut3 = 8'd213;

endpackage

// ===== hw/rtl/odr_bayer_regs.sv =====
module odr_bayer_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [odr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [odr_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [odr_pkg::PhaseW-1:0]    row_phase_i,
  input  logic [odr_pkg::PhaseW-1:0]    col_phase_i,
  output logic [odr_pkg::EntryW-1:0]    entry_o
);

  odr_pkg::bayer_row_t rows_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= odr_pkg::BayerRow0Rst;
      rows_q[1] <= odr_pkg::BayerRow1Rst;
      rows_q[2] <= odr_pkg::BayerRow2Rst;
      rows_q[3] <= odr_pkg::BayerRow3Rst;
    end else if (cfg_we_i) begin
      case (odr_pkg::cfg_reg_e'(cfg_idx_i))
        odr_pkg::REG_BAYER_ROW0: rows_q[0] <= odr_pkg::bayer_row_t'(cfg_data_i);
        odr_pkg::REG_BAYER_ROW1: rows_q[1] <= odr_pkg::bayer_row_t'(cfg_data_i);
        odr_pkg::REG_BAYER_ROW2: rows_q[2] <= odr_pkg::bayer_row_t'(cfg_data_i);
        odr_pkg::REG_BAYER_ROW3: rows_q[3] <= odr_pkg::bayer_row_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // row mux then column slice
  assign entry_o = rows_q[row_phase_i][col_phase_i];

endmodule

// ===== hw/rtl/odr_chan_quant.sv =====
module odr_chan_quant (
  input  logic                         kind_i,
  input  logic [odr_pkg::ChanW-1:0]    chan_i,
  input  logic [odr_pkg::EntryW-1:0]   entry_i,
  output logic [odr_pkg::LevelW-1:0]   level_o
);

  logic [odr_pkg::LevelW-1:0] band;
  logic [odr_pkg::LevelW-1:0] plain_level;
  logic [odr_pkg::LevelW-1:0] dither_level;
  logic [odr_pkg::ChanW-1:0]  diff;
  logic [odr_pkg::CmpW-1:0]   lhs;
  logic [odr_pkg::CmpW-1:0]   rhs;

  always_comb begin
    if (chan_i > odr_pkg::HighCut) begin
      band = 2'd2;
      diff = chan_i - odr_pkg::HighCut;
    end else if (chan_i > odr_pkg::StepVal) begin
      band = 2'd1;
      diff = chan_i - odr_pkg::StepVal;
    end else begin
      band = 2'd0;
      diff = chan_i;
    end
  end

  // diff*32 > entry*172 - 86, moved to the unsigned side
  assign lhs = {diff, 5'b0} + odr_pkg::ThrOff;
  assign rhs = odr_pkg::CmpW'(entry_i) * odr_pkg::ThrMul;
  assign dither_level = (lhs > rhs) ? band + 2'd1 : band;

  always_comb begin
    if (chan_i >= odr_pkg::PlainCut3) begin
      plain_level = 2'd3;
    end else if (chan_i >= odr_pkg::PlainCut2) begin
      plain_level = 2'd2;
    end else if (chan_i >= odr_pkg::PlainCut1) begin
      plain_level = 2'd1;
    end else begin
      plain_level = 2'd0;
    end
  end

  assign level_o = (odr_pkg::kind_e'(kind_i) == odr_pkg::KIND_DITHER) ?
                   dither_level : plain_level;

endmodule

// ===== hw/rtl/ordered_dither_rgb_to_6bit_core.sv =====
// ordered dither color reducer, 24-bit rgb pixel to 6-bit rrggbb code
// pipeline: each word passes through the input reg, then the result reg
// throughput: one word per cycle, sustained while the output side does not stall
// reset: async active low; clears both valid flags and loads the default 4x4
// bayer matrix into the four row registers
module ordered_dither_rgb_to_6bit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [odr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [odr_pkg::CfgW-1:0]      cfg_data_i,

  // pixel input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [odr_pkg::ChanW-1:0]     red_i,
  input  logic [odr_pkg::ChanW-1:0]     green_i,
  input  logic [odr_pkg::ChanW-1:0]     blue_i,
  input  logic [odr_pkg::PhaseW-1:0]    col_phase_i,
  input  logic [odr_pkg::PhaseW-1:0]    row_phase_i,

  // code output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [odr_pkg::CodeW-1:0]     code_o
);

  // input register stage
  logic                        in_vld_q;
  logic                        kind_q;
  logic [odr_pkg::ChanW-1:0]   red_q;
  logic [odr_pkg::ChanW-1:0]   green_q;
  logic [odr_pkg::ChanW-1:0]   blue_q;
  logic [odr_pkg::PhaseW-1:0]  col_q;
  logic [odr_pkg::PhaseW-1:0]  row_q;

  // result register stage
  logic                        out_vld_q;
  logic [odr_pkg::CodeW-1:0]   code_q;
  logic [odr_pkg::CodeW-1:0]   code_d;

  logic                        out_load;
  logic                        in_take;

  logic [odr_pkg::EntryW-1:0]  entry;
  logic [odr_pkg::LevelW-1:0]  lvl_r;
  logic [odr_pkg::LevelW-1:0]  lvl_g;
  logic [odr_pkg::LevelW-1:0]  lvl_b;

  // result reg takes a new word when empty or being drained this cycle
  assign out_load = !out_vld_q || !out_stall_i;
  // input reg frees up when empty or when its word moves into the result reg
  assign in_take  = !in_vld_q || out_load;
  assign in_stall_o = !in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= in_valid_i;
    end
  end

  // pixel fields need no reset
  always_ff @(posedge clk_i) begin
    if (in_take && in_valid_i) begin
      kind_q  <= kind_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      col_q   <= col_phase_i;
      row_q   <= row_phase_i;
    end
  end

  // bayer matrix; user must change rows only while pipe is empty, not enforced
  odr_bayer_regs u_bayer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .row_phase_i (row_q),
    .col_phase_i (col_q),
    .entry_o     (entry)
  );

  // one quantizer per channel, all sharing the same bayer entry
  odr_chan_quant u_quant_r (
    .kind_i  (kind_q),
    .chan_i  (red_q),
    .entry_i (entry),
    .level_o (lvl_r)
  );

  odr_chan_quant u_quant_g (
    .kind_i  (kind_q),
    .chan_i  (green_q),
    .entry_i (entry),
    .level_o (lvl_g)
  );

  odr_chan_quant u_quant_b (
    .kind_i  (kind_q),
    .chan_i  (blue_q),
    .entry_i (entry),
    .level_o (lvl_b)
  );

  // pack as rrggbb
  assign code_d = {lvl_r, lvl_g, lvl_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_vld_q) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign code_o      = code_q;

endmodule

// ===== tb/sv/odr_code_checker.sv =====
`timescale 1ns / 100ps

module odr_code_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [odr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [odr_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         kind_i,
  input  logic [odr_pkg::ChanW-1:0]    red_i,
  input  logic [odr_pkg::ChanW-1:0]    green_i,
  input  logic [odr_pkg::ChanW-1:0]    blue_i,
  input  logic [odr_pkg::PhaseW-1:0]   col_phase_i,
  input  logic [odr_pkg::PhaseW-1:0]   row_phase_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [odr_pkg::CodeW-1:0]    code_i,
  output int                           fail_cnt_o,
  output int                           pending_o,
  output int                           checked_o
);

  localparam int BandStep   = 85;
  localparam int BandHigh   = 170;
  localparam int ThrScale   = 172;
  localparam int ThrBias    = 86;
  localparam int MaxReports = 20;

  typedef struct {
    logic [odr_pkg::CodeW-1:0]  code;
    logic                       kind;
    logic [odr_pkg::ChanW-1:0]  red;
    logic [odr_pkg::ChanW-1:0]  green;
    logic [odr_pkg::ChanW-1:0]  blue;
    logic [odr_pkg::PhaseW-1:0] col;
    logic [odr_pkg::PhaseW-1:0] row;
  } pixel_code_t;

  logic [odr_pkg::CfgW-1:0] bayer_rows [4];
  pixel_code_t              expected_codes [$];
  int                       fail_cnt = 0;
  int                       checked_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign checked_o  = checked_cnt;

  function automatic logic [odr_pkg::LevelW-1:0] plain_level(
      logic [odr_pkg::ChanW-1:0] c);
    return odr_pkg::LevelW'((6 * int'(c) + 255) / 510);
  endfunction

  // band from the cut points, then one level up when past the scaled threshold
  function automatic logic [odr_pkg::LevelW-1:0] dither_level(
      logic [odr_pkg::ChanW-1:0] c, logic [odr_pkg::EntryW-1:0] entry);
    int band;
    int diff;
    int thr;
    if (int'(c) > BandHigh) band = 2;
    else if (int'(c) > BandStep) band = 1;
    else band = 0;
    diff = int'(c) - BandStep * band;
    thr  = int'(entry) * ThrScale - ThrBias;
    return (diff * 32 > thr) ? odr_pkg::LevelW'(band + 1) : odr_pkg::LevelW'(band);
  endfunction

  function automatic logic [odr_pkg::CodeW-1:0] quantize_pixel(pixel_code_t px);
    logic [odr_pkg::EntryW-1:0] entry;
    logic [odr_pkg::LevelW-1:0] lr, lg, lb;
    entry = bayer_rows[px.row][odr_pkg::EntryW * px.col +: odr_pkg::EntryW];
    if (px.kind == odr_pkg::KIND_DITHER) begin
      lr = dither_level(px.red, entry);
      lg = dither_level(px.green, entry);
      lb = dither_level(px.blue, entry);
    end else begin
      lr = plain_level(px.red);
      lg = plain_level(px.green);
      lb = plain_level(px.blue);
    end
    return {lr, lg, lb};
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_cnt < MaxReports) $display("[%0t] code mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_code_t px;
    if (!rst_ni) begin
      bayer_rows[0] = 20'd329984;
      bayer_rows[1] = 20'd211084;
      bayer_rows[2] = 20'd296291;
      bayer_rows[3] = 20'd177391;
      expected_codes.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) bayer_rows[cfg_idx_i] = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("code %02h with no pixel waiting", code_i));
        end else begin
          px = expected_codes.pop_front();
          checked_cnt++;
          if (code_i !== px.code)
            report_mismatch($sformatf(
              "code %02h, expected %02h (kind %0d rgb %02h %02h %02h col %0d row %0d)",
              code_i, px.code, px.kind, px.red, px.green, px.blue, px.col, px.row));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        px.kind  = kind_i;
        px.red   = red_i;
        px.green = green_i;
        px.blue  = blue_i;
        px.col   = col_phase_i;
        px.row   = row_phase_i;
        px.code  = quantize_pixel(px);
        expected_codes.push_back(px);
      end
      pending_o <= expected_codes.size();
    end
  end

endmodule

// ===== tb/sv/tb_ordered_dither_rgb_to_6bit_core.sv =====
`timescale 1ns / 100ps

module tb_ordered_dither_rgb_to_6bit_core;

  // run shape
  localparam int NumPhases  = 8;
  localparam int PerPhase   = 230;
  localparam int LongHold   = 60;     // receiver hold-off, in cycles
  localparam int PressItems = 40;     // back-to-back words offered during the hold-off
  localparam int RunLimitNs = 10_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic                        cfg_we = 1'b0;
  logic [odr_pkg::CfgIdxW-1:0] cfg_idx = odr_pkg::REG_BAYER_ROW0;
  logic [odr_pkg::CfgW-1:0]    cfg_data = '0;

  // pixel channel
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       kind = odr_pkg::KIND_PLAIN;
  logic [odr_pkg::ChanW-1:0]  red = '0;
  logic [odr_pkg::ChanW-1:0]  green = '0;
  logic [odr_pkg::ChanW-1:0]  blue = '0;
  logic [odr_pkg::PhaseW-1:0] col_phase = '0;
  logic [odr_pkg::PhaseW-1:0] row_phase = '0;

  // code channel
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [odr_pkg::CodeW-1:0] code;

  // checker status
  int fail_cnt;
  int pending;
  int checked;

  // stimulus bookkeeping
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_asks = 0;
  int n_plain = 0;
  int n_dither = 0;
  int n_settings = 0;

  // channel values around the band and rounding cut points
  logic [odr_pkg::ChanW-1:0] cut_vals [12] = '{8'd0, 8'd85, 8'd86, 8'd170, 8'd171, 8'd255,
                                               8'd42, 8'd43, 8'd127, 8'd128, 8'd212, 8'd213};

  always #6 clk = ~clk;

  ordered_dither_rgb_to_6bit_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .col_phase_i (col_phase),
    .row_phase_i (row_phase),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .code_o      (code)
  );

  odr_code_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .kind_i      (kind),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .col_phase_i (col_phase),
    .row_phase_i (row_phase),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .code_i      (code),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // uniform half the time, often near a cut point, sometimes the rails
  function automatic logic [odr_pkg::ChanW-1:0] pick_chan();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 4) return odr_pkg::ChanW'($urandom_range(0, 255));
    if (sel < 7) return odr_pkg::ChanW'(int'(cut_vals[$urandom_range(0, 11)])
                                        + int'($urandom_range(0, 4)) - 2);
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
  endfunction

  // realistic bayer row, entries no larger than sixteen
  function automatic logic [odr_pkg::CfgW-1:0] small_entry_row();
    logic [odr_pkg::CfgW-1:0] row_bits;
    for (int c = 0; c < 4; c++)
      row_bits[odr_pkg::EntryW * c +: odr_pkg::EntryW] =
        odr_pkg::EntryW'($urandom_range(0, 16));
    return row_bits;
  endfunction

  // offer one pixel word and hold it until the block takes it
  // called right after a rising edge; returns right after the accepting edge
  task automatic send_pixel(input odr_pkg::kind_e k,
                            input logic [odr_pkg::ChanW-1:0] r, g, b,
                            input logic [odr_pkg::PhaseW-1:0] c, rw);
    in_valid  <= 1'b1;
    kind      <= k;
    red       <= r;
    green     <= g;
    blue      <= b;
    col_phase <= c;
    row_phase <= rw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == odr_pkg::KIND_DITHER) n_dither++;
    else n_plain++;
  endtask

  // random pixel word, optionally after a sender idle burst
  task automatic send_random(input bit may_idle);
    int              gap;
    odr_pkg::kind_e  k;
    if (may_idle && tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    k = ($urandom_range(0, 3) != 0) ? odr_pkg::KIND_DITHER : odr_pkg::KIND_PLAIN;
    send_pixel(k, pick_chan(), pick_chan(), pick_chan(),
               odr_pkg::PhaseW'($urandom_range(0, 3)),
               odr_pkg::PhaseW'($urandom_range(0, 3)));
  endtask

  // stop offering and let every expected code come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all four bayer rows, one register per cycle; block must be idle
  task automatic load_bayer(input logic [odr_pkg::CfgW-1:0] r0, r1, r2, r3);
    logic [odr_pkg::CfgW-1:0] rows [4];
    odr_pkg::cfg_reg_e        regs [4];
    rows[0] = r0;
    rows[1] = r1;
    rows[2] = r2;
    rows[3] = r3;
    regs = '{odr_pkg::REG_BAYER_ROW0, odr_pkg::REG_BAYER_ROW1,
             odr_pkg::REG_BAYER_ROW2, odr_pkg::REG_BAYER_ROW3};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= rows[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int hold_done;
    int burst;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // hard limit on the whole run
  initial begin : watchdog
    #(RunLimitNs);
    $display("timeout after %0d ns, %0d codes still expected", RunLimitNs, pending);
    $display("ordered_dither_rgb_to_6bit_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, bayer matrix as left by reset
    // every row and column phase once, channels on the band and rounding cut points
    for (int i = 0; i < 16; i++)
      send_pixel(odr_pkg::KIND_DITHER, cut_vals[i % 12], cut_vals[(i + 4) % 12],
                 cut_vals[(i + 8) % 12], odr_pkg::PhaseW'(i % 4), odr_pkg::PhaseW'(i / 4));
    // plain rounding on both sides of each cut point
    send_pixel(odr_pkg::KIND_PLAIN, 8'd0, 8'd42, 8'd43, 2'd0, 2'd0);
    send_pixel(odr_pkg::KIND_PLAIN, 8'd127, 8'd128, 8'd212, 2'd1, 2'd2);
    send_pixel(odr_pkg::KIND_PLAIN, 8'd213, 8'd255, 8'd85, 2'd2, 2'd1);
    send_pixel(odr_pkg::KIND_PLAIN, 8'd86, 8'd170, 8'd171, 2'd3, 2'd3);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: load_bayer(odr_pkg::BayerRow0Rst, odr_pkg::BayerRow1Rst,
                      odr_pkg::BayerRow2Rst, odr_pkg::BayerRow3Rst);
        1: load_bayer('0, '0, '0, '0);
        2: load_bayer('1, '1, '1, '1);
        NumPhases - 1: load_bayer(small_entry_row(), small_entry_row(),
                                  small_entry_row(), small_entry_row());
        default: load_bayer(odr_pkg::CfgW'($urandom), odr_pkg::CfgW'($urandom),
                            odr_pkg::CfgW'($urandom), odr_pkg::CfgW'($urandom));
      endcase

      // zero entry: every channel one level above its band
      // full-scale entry: every channel stays at its band
      if (ph == 1 || ph == 2) begin
        send_pixel(odr_pkg::KIND_DITHER, 8'd0, 8'd85, 8'd255, 2'd0, 2'd3);
        send_pixel(odr_pkg::KIND_DITHER, 8'd86, 8'd170, 8'd171, 2'd3, 2'd0);
      end

      // closing stretch runs at full rate on both sides
      if (ph == NumPhases - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end

      // one long output hold-off while words keep coming back to back
      if (ph == 3) hold_asks++;

      for (int n = 0; n < PerPhase; n++)
        send_random(!(ph == 3 && n < PressItems));
    end
    drain();

    $display("covered %0d pixel words (%0d plain, %0d dithered), %0d codes checked",
             n_plain + n_dither, n_plain, n_dither, checked);
    $display("across %0d bayer settings incl. zero and full-scale entries,",
             n_settings + 1);
    $display("with a %0d-cycle hold-off", LongHold);
    if (fail_cnt == 0) begin
      $display("ordered_dither_rgb_to_6bit_core regression: pass");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("ordered_dither_rgb_to_6bit_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/odr_pkg.sv
hw/rtl/odr_bayer_regs.sv
hw/rtl/odr_chan_quant.sv
hw/rtl/ordered_dither_rgb_to_6bit_core.sv
tb/sv/odr_code_checker.sv
tb/sv/tb_ordered_dither_rgb_to_6bit_core.sv
